// ===== hdl/dsmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmr_pkg
// Types and constants shared by the diagonal scan matrix reorder block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsmr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned DIM_RESET = 8;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic {
    PH_UPPER = 1'b0,
    PH_LOWER = 1'b1
  } phase_e;

  typedef struct packed {
    action_e                   action;
    logic signed [DATA_W-1:0]  element_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  out_value;
    logic                      last_of_matrix;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/diagonal_scan_matrix_reorder.sv =====
// ----------------------------------------------------------------------------
// diagonal_scan_matrix_reorder
// Stores an N-by-N matrix in row-major order and reads it back in
// anti-diagonal scan order, ending at element (0,0).
// ----------------------------------------------------------------------------
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_ready_o   dsmr_pkg::in_word_t
//   out      out  out_valid_o / out_ready_i dsmr_pkg::out_word_t
//   cfg      in   cfg_valid_i / cfg_ready_o dimension, 7 bits
//
// One word per cycle on the input while the output drains. A read word's
// result passes through the RAM read register, which loads at the accepting
// edge, and then the output register, which loads once the output has room.
// A load word yields nothing. With the output stalled, words keep flowing
// until a read waits in the RAM stage; the input then holds until the output
// word is taken.
// Reset clears control state only; no RAM clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module diagonal_scan_matrix_reorder #(
  parameter int unsigned MAX_DIM = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire dsmr_pkg::in_word_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output dsmr_pkg::out_word_t              out_data_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dsmr_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NNW   = $clog2(DEPTH + 1);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned SW    = DW + 1;
  localparam int unsigned EW    = (DW > dsmr_pkg::CFG_W) ? DW : dsmr_pkg::CFG_W;
  localparam int unsigned PW    = CW + DW;
  localparam int unsigned DIM_RST =
    (dsmr_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : dsmr_pkg::DIM_RESET;

  // configuration
  logic [DW-1:0]  dim_q, dim_d;
  logic [NNW-1:0] nn_q, nn_d;
  logic [EW-1:0]  cfg_ext;
  logic           cfg_acc;

  // counters
  logic [AW-1:0]     lp_q, lp_d;
  logic [CW-1:0]     diag_q, diag_d;
  logic [CW-1:0]     pos_q, pos_d;
  dsmr_pkg::phase_e  phase_q, phase_d;

  // pipeline
  logic                s1_v_q, s1_v_d;
  logic                s1_last_q, s1_last_d;
  logic                out_v_q, out_v_d;
  dsmr_pkg::out_word_t out_q, out_d;
  logic                s1_move;

  logic                in_acc, is_read, is_load;
  logic [SW-1:0]       n_w, d_w, i_w, i_nx, row_w, col_w;
  logic                last_c;
  logic [PW-1:0]       prod;
  logic [AW-1:0]       rd_addr, ram_addr;
  logic [NNW-1:0]      lp_inc;
  logic [dsmr_pkg::DATA_W-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign cfg_ext     = EW'(cfg_data_i);

  always_comb begin
    dim_d = dim_q;
    nn_d  = nn_q;
    if (cfg_acc) begin
      if (cfg_ext == '0) begin
        dim_d = DW'(1);
      end else if (cfg_ext > EW'(MAX_DIM)) begin
        dim_d = DW'(MAX_DIM);
      end else begin
        dim_d = DW'(cfg_ext);
      end
      nn_d = NNW'(dim_d * dim_d);
    end
  end

  assign s1_move    = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_move;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_read    = in_acc && (in_data_i.action == dsmr_pkg::ACT_READ);
  assign is_load    = in_acc && (in_data_i.action == dsmr_pkg::ACT_LOAD);

  // scan position
  assign n_w  = SW'(dim_q);
  assign d_w  = SW'(diag_q);
  assign i_w  = SW'(pos_q);
  assign i_nx = i_w + SW'(1);

  always_comb begin
    diag_d  = diag_q;
    pos_d   = pos_q;
    phase_d = phase_q;
    last_c  = 1'b0;
    unique case (phase_q)
      dsmr_pkg::PH_UPPER: begin
        row_w = n_w - SW'(1) - d_w - i_w;
        col_w = i_w;
        pos_d = CW'(i_nx);
        if (i_nx >= n_w - d_w) begin
          pos_d = '0;
          if (d_w + SW'(1) >= n_w) begin
            last_c = 1'b1;
            diag_d = '0;
          end else begin
            phase_d = dsmr_pkg::PH_LOWER;
          end
        end
      end
      dsmr_pkg::PH_LOWER: begin
        row_w = d_w + SW'(1) + i_w;
        col_w = n_w - SW'(1) - i_w;
        pos_d = CW'(i_nx);
        if (i_nx >= n_w - SW'(1) - d_w) begin
          diag_d  = CW'(d_w + SW'(1));
          pos_d   = '0;
          phase_d = dsmr_pkg::PH_UPPER;
        end
      end
      default: begin
        row_w = '0;
        col_w = '0;
      end
    endcase
    if (!is_read) begin
      diag_d  = diag_q;
      pos_d   = pos_q;
      phase_d = phase_q;
    end
    if (cfg_acc) begin
      diag_d  = '0;
      pos_d   = '0;
      phase_d = dsmr_pkg::PH_UPPER;
    end
  end

  assign prod    = PW'(CW'(row_w)) * PW'(dim_q);
  assign rd_addr = AW'(prod + PW'(CW'(col_w)));

  // load position
  assign lp_inc = NNW'(lp_q) + NNW'(1);
  always_comb begin
    lp_d = lp_q;
    if (is_load) begin
      lp_d = (lp_inc >= nn_q) ? '0 : AW'(lp_inc);
    end
    if (cfg_acc) begin
      lp_d = '0;
    end
  end

  assign ram_addr = is_load ? lp_q : rd_addr;

  dsmr_ram #(
    .WIDTH (dsmr_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .we_i    (is_load),
    .addr_i  (ram_addr),
    .wdata_i (in_data_i.element_value),
    .rdata_o (ram_rdata)
  );

  // result pipeline
  always_comb begin
    s1_v_d    = s1_v_q;
    s1_last_d = s1_last_q;
    out_v_d   = out_v_q;
    out_d     = out_q;
    if (out_v_q && out_ready_i) begin
      out_v_d = 1'b0;
    end
    if (s1_move) begin
      s1_v_d               = 1'b0;
      out_v_d              = 1'b1;
      out_d.out_value      = ram_rdata;
      out_d.last_of_matrix = s1_last_q;
    end
    if (is_read) begin
      s1_v_d    = 1'b1;
      s1_last_d = last_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DW'(DIM_RST);
      nn_q    <= NNW'(DIM_RST * DIM_RST);
      lp_q    <= '0;
      diag_q  <= '0;
      pos_q   <= '0;
      phase_q <= dsmr_pkg::PH_UPPER;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      dim_q   <= dim_d;
      nn_q    <= nn_d;
      lp_q    <= lp_d;
      diag_q  <= diag_d;
      pos_q   <= pos_d;
      phase_q <= phase_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_last_q <= s1_last_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/dsmr_ram.sv =====
// ----------------------------------------------------------------------------
// dsmr_ram
// Generic single-port RAM, a write or a registered read on each enabled access.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== bench/tb_diagonal_scan_matrix_reorder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diagonal_scan_matrix_reorder
// Loads matrices of several sizes, reads them back and checks every read word
// against an in-bench anti-diagonal scan of the loaded elements. Random idle
// cycles on both channels; dimension is rewritten between drained phases.
// ----------------------------------------------------------------------------
module tb_diagonal_scan_matrix_reorder;

  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  dsmr_pkg::in_word_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dsmr_pkg::out_word_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dsmr_pkg::CFG_W-1:0]    cfg_data = '0;

  diagonal_scan_matrix_reorder #(
    .MAX_DIM(MAX_DIM)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scan state mirrored from the block
  int unsigned                        scan_n = dsmr_pkg::DIM_RESET;
  int unsigned                        load_pos = 0;
  int unsigned                        diag_d = 0;
  int unsigned                        diag_i = 0;
  dsmr_pkg::phase_e                   diag_side = dsmr_pkg::PH_UPPER;
  logic signed [dsmr_pkg::DATA_W-1:0] elem_mem [MAX_DIM*MAX_DIM];
  bit                                 elem_loaded [MAX_DIM*MAX_DIM];

  dsmr_pkg::in_word_t    word_q [$];
  dsmr_pkg::out_word_t   scan_q [$];
  int          errors = 0;
  int          items_made = 0;
  int          in_calm = 0;
  int          out_calm = 0;
  int          idle_left = 0;
  int          stall_left = 0;
  int unsigned cycles = 0;

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic int unsigned scan_addr();
    if (diag_side == dsmr_pkg::PH_UPPER) begin
      return (scan_n - 1 - diag_d - diag_i) * scan_n + diag_i;
    end
    return (diag_d + 1 + diag_i) * scan_n + (scan_n - 1 - diag_i);
  endfunction

  // step to the next scan position; returns 1 when (0,0) was just read
  function automatic bit advance_scan();
    bit last;
    last = 1'b0;
    diag_i++;
    if (diag_side == dsmr_pkg::PH_UPPER) begin
      if (diag_i >= scan_n - diag_d) begin
        diag_i = 0;
        if (diag_d + 1 >= scan_n) begin
          last = 1'b1;
          diag_d = 0;
        end else begin
          diag_side = dsmr_pkg::PH_LOWER;
        end
      end
    end else if (diag_i >= scan_n - 1 - diag_d) begin
      diag_d++;
      diag_i = 0;
      diag_side = dsmr_pkg::PH_UPPER;
    end
    return last;
  endfunction

  function automatic logic [dsmr_pkg::DATA_W-1:0] rand_element();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(logic [dsmr_pkg::DATA_W-1:0] v);
    dsmr_pkg::in_word_t w;
    w.action = dsmr_pkg::ACT_LOAD;
    w.element_value = v;
    word_q.push_back(w);
    elem_mem[load_pos] = v;
    elem_loaded[load_pos] = 1'b1;
    load_pos = (load_pos + 1 >= scan_n * scan_n) ? 0 : load_pos + 1;
    items_made++;
  endtask

  task automatic push_read();
    dsmr_pkg::in_word_t    w;
    dsmr_pkg::out_word_t   e;
    int unsigned a;
    w.action = dsmr_pkg::ACT_READ;
    w.element_value = $urandom;
    word_q.push_back(w);
    a = scan_addr();
    e.out_value = elem_mem[a];
    e.last_of_matrix = advance_scan();
    scan_q.push_back(e);
    items_made++;
  endtask

  // reads only where the next scan entry holds a loaded element
  task automatic mix_words(int count, int read_pct);
    for (int k = 0; k < count; k++) begin
      if (elem_loaded[scan_addr()] && $urandom_range(0, 99) < read_pct) push_read();
      else push_load(rand_element());
    end
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid || scan_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dim(logic [dsmr_pkg::CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scan_n = (v == 0) ? 1 : (v > MAX_DIM) ? MAX_DIM : v;
    load_pos = 0;
    diag_d = 0;
    diag_i = 0;
    diag_side = dsmr_pkg::PH_UPPER;
    @(negedge clk);
  endtask

  always @(posedge clk or negedge rst_n) begin : in_side
    int g;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      idle_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        in_valid  <= 1'b0;
      end else if (word_q.size() != 0) begin
        in_data  <= word_q.pop_front();
        in_valid <= 1'b1;
        g = pick_gap(in_calm);
        idle_left <= g;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : out_side
    int                  g;
    dsmr_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (scan_q.size() == 0) begin
          if (errors < 10) $display("unexpected word: value %0d last %b",
                                    out_data.out_value, out_data.last_of_matrix);
          errors++;
        end else begin
          want = scan_q.pop_front();
          if (out_data.out_value !== want.out_value ||
              out_data.last_of_matrix !== want.last_of_matrix) begin
            if (errors < 10) $display("mismatch: value exp %0d got %0d, last exp %b got %b",
                                      want.out_value, out_data.out_value,
                                      want.last_of_matrix, out_data.last_of_matrix);
            errors++;
          end
        end
        g = pick_gap(out_calm);
        stall_left <= g;
        out_ready  <= (g == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("diagonal_scan_matrix_reorder regression: fail");
      $finish;
    end
  end

  initial begin : stim
    int unsigned r;
    logic [dsmr_pkg::CFG_W-1:0] v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset dimension of 8
    for (int k = 0; k < 64; k++) push_load(rand_element());
    mix_words(90, 80);

    // N=1 with wrap on the extra load, then N=2 with a restart mid-scan
    write_dim(dsmr_pkg::CFG_W'(0));
    push_load(32'h8000_0000);
    push_read();
    push_load(32'h7FFF_FFFF);
    push_read();
    write_dim(dsmr_pkg::CFG_W'(2));
    push_load(32'h0000_0000);
    push_load(32'hFFFF_FFFF);
    push_load(32'h7FFF_FFFF);
    push_load(32'h8000_0000);
    push_read();
    push_read();
    write_dim(dsmr_pkg::CFG_W'(2));
    push_load(32'h1234_5678);
    repeat (4) push_read();

    while (items_made < 950) begin
      r = $urandom_range(0, 99);
      if (r < 60) v = dsmr_pkg::CFG_W'($urandom_range(1, 8));
      else if (r < 90) v = dsmr_pkg::CFG_W'($urandom_range(9, 16));
      else v = dsmr_pkg::CFG_W'($urandom_range(0, 127));
      write_dim(v);
      if (scan_n <= 16 && $urandom_range(0, 99) < 60) begin
        for (int k = 0; k < scan_n * scan_n; k++) push_load(rand_element());
        mix_words($urandom_range(scan_n * scan_n, 3 * scan_n * scan_n + 4) % 200 + 4, 75);
      end else begin
        mix_words($urandom_range(20, 120), $urandom_range(10, 90));
      end
    end

    // largest dimension, then an out-of-range one that clamps to it
    write_dim(dsmr_pkg::CFG_W'(MAX_DIM));
    mix_words(150, 90);
    write_dim(dsmr_pkg::CFG_W'(127));
    mix_words(100, 70);

    wait_drained();
    repeat (8) @(posedge clk);
    if (scan_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("diagonal_scan_matrix_reorder regression: pass");
    end else begin
      $display("diagonal_scan_matrix_reorder regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dsmr_pkg.sv
hdl/dsmr_ram.sv
hdl/diagonal_scan_matrix_reorder.sv
bench/tb_diagonal_scan_matrix_reorder.sv
